### rtl/kvt_pkg.sv
// Types, character codes and byte classes shared by the key-value text tokenizer.
package kvt_pkg;

	localparam int FIELD_BITS = 24;
	// a byte can walk through at most three lexer modes before it is consumed
	localparam int LEX_PASSES = 3;
	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'd0,
		MODE_CRIDLE   = 4'd1,
		MODE_SLASH    = 4'd2,
		MODE_UNQUOTED = 4'd3,
		MODE_COMMENT  = 4'd4,
		MODE_QOPEN    = 4'd5,
		MODE_QBODY    = 4'd6,
		MODE_QESC     = 4'd7
	} lexer_mode_t;

	typedef enum logic [2:0] {
		TK_NEWLINE  = 3'd0,
		TK_LBRACE   = 3'd1,
		TK_RBRACE   = 3'd2,
		TK_LBRACKET = 3'd3,
		TK_RBRACKET = 3'd4,
		TK_STRING   = 3'd5,
		TK_END      = 3'd6
	} token_kind_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		token_kind_t           token_kind;
		logic [FIELD_BITS-1:0] start_offset;
		logic [FIELD_BITS-1:0] end_offset;
		logic                  warning;
		logic                  last_token;
	} token_item_t;

	function automatic logic is_print(logic [7:0] b);
		return (b >= CH_SPACE) && (b <= CH_TILDE);
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_quote(logic [7:0] b);
		return (b == CH_DQUOTE) || (b == CH_SQUOTE);
	endfunction

	function automatic logic is_bracket(logic [7:0] b);
		return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) || (b == CH_RBRACK);
	endfunction

	function automatic logic is_escape(logic [7:0] b);
		return (b == CH_BSLASH) || (b == CH_SQUOTE) || (b == CH_DQUOTE) ||
			(b == CH_LOW_N) || (b == CH_LOW_T) || (b == CH_LOW_R);
	endfunction

endpackage

### rtl/key_value_text_tokenizer_top.sv
// Key-value text tokenizer: byte input stage, lexer state machine and token queue.
//
// Usage: bytes of a document enter on text_item (valid/ready), one item per byte; a zero
// byte, end_of_text, or a non-printable non-blank byte between tokens ends the document
// and offsets restart at 0 for the next byte. Tokens leave on token_item (valid/ready),
// one per item, with last_token marking the final token caused by a given byte.
// Each byte causes zero, one or two tokens; a token can appear one byte late since some
// tokens need one byte of lookahead.
// A token caused by a byte is made from the staged byte and offered from the token queue.
// Throughput: one byte per cycle when the queue has room; the lexer step is combinational.
// Tokens drain from a four-entry queue at one per cycle while token_ready is high;
// a byte that yields two tokens takes two entries, so a run of them is output-limited.
// Stalls: the lexer steps only while the queue has room for two tokens; when the
// receiver holds token_ready low the queue fills and text_ready drops once the staged
// byte cannot be processed. Nothing is dropped.
// Reset (arst_n low): lexer idle, offsets zero, input stage and queue empty.
module key_value_text_tokenizer_top #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_ready,
	input  kvt_pkg::text_item_t  text_item,
	output logic                 token_valid,
	input  logic                 token_ready,
	output kvt_pkg::token_item_t token_item
);
	import kvt_pkg::*;

	localparam int PTR_BITS = $clog2(FIFO_DEPTH);

	// input stage
	logic            valid_s1;
	logic [7:0]      byte_s1;

	// lexer state
	lexer_mode_t            mode_q, mode_d;
	logic                   quote_single_q, quote_single_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [OFFSET_BITS-1:0] tok_start_q, tok_start_d;
	logic [OFFSET_BITS-1:0] content_end_q, content_end_d;

	// token queue
	token_item_t         fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	logic        fire;
	logic        text_acc;
	logic        pop;
	token_item_t tok [2];
	logic [1:0]  tok_n;

	function automatic logic [FIELD_BITS-1:0] to_field(logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[FIELD_BITS-1:0];
	endfunction

	function automatic token_item_t make_tok(token_kind_t kind, logic [OFFSET_BITS-1:0] s,
			logic [OFFSET_BITS-1:0] e, logic warn);
		token_item_t t;
		logic        str;
		str = (kind == TK_STRING);
		t.token_kind   = kind;
		t.start_offset = str ? to_field(s) : '0;
		t.end_offset   = str ? to_field(e) : '0;
		t.warning      = str & warn;
		t.last_token   = 1'b0;
		return t;
	endfunction

	assign fire       = valid_s1 && (count_q <= (PTR_BITS+1)'(FIFO_DEPTH - 2));
	assign text_ready = !valid_s1 || fire;
	assign text_acc   = text_valid && text_ready;
	assign pop        = token_valid && token_ready;

	assign token_valid = (count_q != '0);
	assign token_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_acc) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// end_of_text is folded into a zero byte here
	always_ff @(posedge clk) begin
		if (text_acc) begin
			byte_s1 <= text_item.end_of_text ? CH_NUL : text_item.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			quote_single_q <= 1'b0;
			offset_q       <= '0;
			tok_start_q    <= '0;
			content_end_q  <= '0;
		end else if (fire) begin
			mode_q         <= mode_d;
			quote_single_q <= quote_single_d;
			offset_q       <= offset_d;
			tok_start_q    <= tok_start_d;
			content_end_q  <= content_end_d;
		end
	end

	// One lexer step: the byte may be re-examined after a mode ends on it.
	always_comb begin
		lexer_mode_t            mode_v;
		logic                   qs_v;
		logic [OFFSET_BITS-1:0] ts_v;
		logic [OFFSET_BITS-1:0] ce_v;
		logic [OFFSET_BITS-1:0] p;
		logic [OFFSET_BITS-1:0] p1;
		logic [7:0]             b;
		logic [7:0]             q;
		logic                   done;
		logic                   ended;

		mode_v = mode_q;
		qs_v   = quote_single_q;
		ts_v   = tok_start_q;
		ce_v   = content_end_q;
		p      = offset_q;
		p1     = OFFSET_BITS'(offset_q + 1'b1);
		b      = byte_s1;
		q      = CH_DQUOTE;
		done   = 1'b0;
		ended  = 1'b0;
		tok_n  = '0;
		tok[0] = make_tok(TK_NEWLINE, '0, '0, 1'b0);
		tok[1] = make_tok(TK_NEWLINE, '0, '0, 1'b0);

		for (int i = 0; i < LEX_PASSES; i++) begin
			if (!done) begin
				unique case (mode_v)
					MODE_CRIDLE: begin
						mode_v = MODE_IDLE;
						if (b == CH_LF) begin
							done = 1'b1;
						end
					end
					MODE_IDLE: begin
						done = 1'b1;
						if (b == CH_NUL || (!is_print(b) && !is_blank(b))) begin
							tok[tok_n[0]] = make_tok(TK_END, '0, '0, 1'b0);
							tok_n = tok_n + 2'd1;
							ended = 1'b1;
						end else if (b == CH_LF) begin
							tok[tok_n[0]] = make_tok(TK_NEWLINE, '0, '0, 1'b0);
							tok_n = tok_n + 2'd1;
						end else if (is_blank(b)) begin
							mode_v = (b == CH_CR) ? MODE_CRIDLE : MODE_IDLE;
						end else if (b == CH_LBRACE) begin
							tok[tok_n[0]] = make_tok(TK_LBRACE, '0, '0, 1'b0);
							tok_n = tok_n + 2'd1;
						end else if (b == CH_RBRACE) begin
							tok[tok_n[0]] = make_tok(TK_RBRACE, '0, '0, 1'b0);
							tok_n = tok_n + 2'd1;
						end else if (b == CH_LBRACK) begin
							tok[tok_n[0]] = make_tok(TK_LBRACKET, '0, '0, 1'b0);
							tok_n = tok_n + 2'd1;
						end else if (b == CH_RBRACK) begin
							tok[tok_n[0]] = make_tok(TK_RBRACKET, '0, '0, 1'b0);
							tok_n = tok_n + 2'd1;
						end else if (b == CH_SLASH) begin
							ts_v   = p;
							mode_v = MODE_SLASH;
						end else if (is_quote(b)) begin
							qs_v   = (b == CH_SQUOTE);
							mode_v = MODE_QOPEN;
						end else begin
							ts_v   = p;
							mode_v = MODE_UNQUOTED;
						end
					end
					MODE_SLASH: begin
						if (b == CH_SLASH) begin
							mode_v = MODE_COMMENT;
							done   = 1'b1;
						end else begin
							mode_v = MODE_UNQUOTED;
						end
					end
					MODE_UNQUOTED: begin
						if (b == CH_SPACE || b == CH_TAB || b == CH_LF || !is_print(b) ||
								is_bracket(b) || is_quote(b)) begin
							tok[tok_n[0]] = make_tok(TK_STRING, ts_v, p, is_quote(b));
							tok_n  = tok_n + 2'd1;
							mode_v = MODE_IDLE;
						end else begin
							done = 1'b1;
						end
					end
					MODE_COMMENT: begin
						if (b == CH_LF || !is_print(b) || is_bracket(b) || is_quote(b)) begin
							mode_v = MODE_IDLE;
						end else begin
							done = 1'b1;
						end
					end
					MODE_QOPEN: begin
						if (is_quote(b)) begin
							tok[tok_n[0]] = make_tok(TK_STRING, p, p, 1'b0);
							tok_n  = tok_n + 2'd1;
							mode_v = MODE_IDLE;
							done   = 1'b1;
						end else begin
							ts_v   = p;
							ce_v   = p;
							mode_v = MODE_QBODY;
						end
					end
					MODE_QBODY: begin
						q = qs_v ? CH_SQUOTE : CH_DQUOTE;
						if (b == q) begin
							if (ce_v != ts_v) begin
								tok[tok_n[0]] = make_tok(TK_STRING, ts_v, ce_v, 1'b0);
								tok_n = tok_n + 2'd1;
							end
							mode_v = MODE_IDLE;
							done   = 1'b1;
						end else if (b == CH_LF || b == CH_NUL) begin
							if (ce_v != ts_v) begin
								tok[tok_n[0]] = make_tok(TK_STRING, ts_v, ce_v, 1'b1);
								tok_n = tok_n + 2'd1;
							end
							mode_v = MODE_IDLE;
						end else if (!is_print(b)) begin
							// broken string: the byte is eaten, a CR also eats its LF
							if (ce_v != ts_v) begin
								tok[tok_n[0]] = make_tok(TK_STRING, ts_v, ce_v, 1'b1);
								tok_n = tok_n + 2'd1;
							end
							mode_v = (b == CH_CR) ? MODE_CRIDLE : MODE_IDLE;
							done   = 1'b1;
						end else begin
							// trim: spaces only move the end once real content follows
							if (b != CH_SPACE) begin
								if (ce_v == ts_v) begin
									ts_v = p;
								end
								ce_v = p1;
							end
							mode_v = (b == CH_BSLASH) ? MODE_QESC : MODE_QBODY;
							done   = 1'b1;
						end
					end
					MODE_QESC: begin
						mode_v = MODE_QBODY;
						if (is_escape(b)) begin
							ce_v = p1;
							done = 1'b1;
						end
					end
					default: begin
						mode_v = MODE_IDLE;
					end
				endcase
			end
		end

		if (tok_n == 2'd1) begin
			tok[0].last_token = 1'b1;
		end else if (tok_n == 2'd2) begin
			tok[1].last_token = 1'b1;
		end

		if (ended) begin
			mode_d         = MODE_IDLE;
			quote_single_d = 1'b0;
			offset_d       = '0;
			tok_start_d    = '0;
			content_end_d  = '0;
		end else begin
			mode_d         = mode_v;
			quote_single_d = qs_v;
			offset_d       = p1;
			tok_start_d    = ts_v;
			content_end_d  = ce_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= PTR_BITS'(wr_ptr_q + tok_n);
			end
			if (pop) begin
				rd_ptr_q <= PTR_BITS'(rd_ptr_q + 1'b1);
			end
			count_q <= (PTR_BITS+1)'(count_q + (fire ? (PTR_BITS+1)'(tok_n) : '0) -
				(pop ? (PTR_BITS+1)'(1) : '0));
		end
	end

	always_ff @(posedge clk) begin
		if (fire && tok_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= tok[0];
		end
		if (fire && tok_n == 2'd2) begin
			fifo_q[PTR_BITS'(wr_ptr_q + 1'b1)] <= tok[1];
		end
	end

endmodule
